[rtl/met_pkg.sv]
// Package for the Mandelbrot escape-time core: widths, reset values,
// register indexes, controller states and the structs between modules.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package met_pkg;

	localparam int FRAC_BITS  = 26;
	localparam int COORD_W    = 12;
	localparam int ORIGIN_W   = 32;
	localparam int STEP_W     = 22;
	localparam int LIMIT_W    = 34;
	localparam int ITER_W     = 8;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 34;

	// position * step is COORD_W+STEP_W+1 bits signed; one more for the origin add
	localparam int OFF_W = COORD_W + STEP_W + 1;
	localparam int C_W   = OFF_W + 1;
	// a component at or above 2^MAG_W squares to more than any escape limit
	localparam int MAG_W = (LIMIT_W + FRAC_BITS) / 2;
	localparam int PROD_W = 2 * MAG_W;
	localparam int SQ_W  = PROD_W - FRAC_BITS;
	localparam int X2_W  = SQ_W + 1;
	localparam int T_W   = C_W + 2;

	localparam logic signed [ORIGIN_W-1:0] RE_ORIGIN_RST = -32'sd134217728;
	localparam logic signed [ORIGIN_W-1:0] IM_ORIGIN_RST = -32'sd67108864;
	localparam logic signed [STEP_W-1:0]   RE_STEP_RST   = 22'sd40960;
	localparam logic signed [STEP_W-1:0]   IM_STEP_RST   = 22'sd32768;
	localparam logic [LIMIT_W-1:0]         LIMIT_RST     = 34'd1342177280;
	localparam logic [ITER_W-1:0]          MAX_ITERS_RST = 8'd255;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_RE_ORIGIN = 3'd0,
		REG_IM_ORIGIN = 3'd1,
		REG_RE_STEP   = 3'd2,
		REG_IM_STEP   = 3'd3,
		REG_LIMIT     = 3'd4,
		REG_MAX_ITERS = 3'd5
	} cfg_reg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOAD,
		ST_ADD,
		ST_MUL,
		ST_FIN
	} state_t;

	typedef struct packed {
		logic signed [ORIGIN_W-1:0] re_origin;
		logic signed [ORIGIN_W-1:0] im_origin;
		logic signed [STEP_W-1:0]   re_step;
		logic signed [STEP_W-1:0]   im_step;
		logic [LIMIT_W-1:0]         escape_limit;
		logic [ITER_W-1:0]          max_iters;
	} cfg_t;

	typedef struct packed {
		logic capture;
		logic load;
		logic step;
		logic mul;
		logic fin;
	} cmd_t;

	typedef struct packed {
		logic done;
	} sts_t;

endpackage

`default_nettype wire

[rtl/met_cfg.sv]
// Configuration register file of the escape-time core.
// Depends on met_pkg.
`timescale 1ns / 1ps
`default_nettype none

module met_cfg import met_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	output cfg_t                       cfg
);

	cfg_t regs_q;

	assign cfg_ready = 1'b1;
	assign cfg       = regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.re_origin    <= RE_ORIGIN_RST;
			regs_q.im_origin    <= IM_ORIGIN_RST;
			regs_q.re_step      <= RE_STEP_RST;
			regs_q.im_step      <= IM_STEP_RST;
			regs_q.escape_limit <= LIMIT_RST;
			regs_q.max_iters    <= MAX_ITERS_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_reg_t'(cfg_index))
				REG_RE_ORIGIN: regs_q.re_origin    <= cfg_data[ORIGIN_W-1:0];
				REG_IM_ORIGIN: regs_q.im_origin    <= cfg_data[ORIGIN_W-1:0];
				REG_RE_STEP:   regs_q.re_step      <= cfg_data[STEP_W-1:0];
				REG_IM_STEP:   regs_q.im_step      <= cfg_data[STEP_W-1:0];
				REG_LIMIT:     regs_q.escape_limit <= cfg_data[LIMIT_W-1:0];
				REG_MAX_ITERS: regs_q.max_iters    <= cfg_data[ITER_W-1:0];
				default: begin
				end
			endcase
		end
	end

endmodule

`default_nettype wire

[rtl/met_ctrl.sv]
// Controller state machine of the escape-time core: sequences load, add and
// multiply steps and owns both handshakes. Depends on met_pkg.
`timescale 1ns / 1ps
`default_nettype none

module met_ctrl import met_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic      in_stall,
	output logic      out_valid,
	input  wire logic out_stall,
	input  wire sts_t sts,
	output cmd_t      cmd
);

	state_t state_q, state_d;
	logic   out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = ST_LOAD;
				end
			end
			ST_LOAD: begin
				cmd.load = 1'b1;
				state_d  = ST_ADD;
			end
			ST_ADD: begin
				cmd.step = 1'b1;
				state_d  = sts.done ? ST_FIN : ST_MUL;
			end
			ST_MUL: begin
				cmd.mul = 1'b1;
				state_d = ST_ADD;
			end
			ST_FIN: begin
				if (!out_valid_q || !out_stall) begin
					cmd.fin = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.fin) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;

	a_accept_loads: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> (state_q == ST_LOAD))
		else $error("accepted word not followed by load");

	a_mul_then_add: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MUL) |=> (state_q == ST_ADD))
		else $error("multiply step not followed by add step");

	a_valid_from_fin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_FIN))
		else $error("result raised outside finish state");

	a_fin_waits: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FIN && out_valid_q && out_stall) |=> (state_q == ST_FIN))
		else $error("finish left while output register is held");

endmodule

`default_nettype wire

[rtl/met_dpath.sv]
// Datapath of the escape-time core: c formation, the add and multiply halves
// of one iteration, the iteration counter and the output register.
// Depends on met_pkg.
`timescale 1ns / 1ps
`default_nettype none

module met_dpath import met_pkg::*; (
	input  wire logic               clk,
	input  wire logic [COORD_W-1:0] pixel_col,
	input  wire logic [COORD_W-1:0] pixel_row,
	input  wire cfg_t               cfg,
	input  wire cmd_t               cmd,
	output sts_t                    sts,
	output logic [ITER_W-1:0]       gray_value,
	output logic [COORD_W-1:0]      out_col,
	output logic [COORD_W-1:0]      out_row
);

	logic [COORD_W-1:0]      col_q, row_q;
	logic signed [C_W-1:0]   cr_q, ci_q;
	logic signed [T_W-1:0]   tr_q, ti_q;
	logic [SQ_W-1:0]         sq_re_q, sq_im_q;
	logic [X2_W-1:0]         x2_q;
	logic                    big_q, neg_q, pend_q;
	logic [ITER_W-1:0]       cnt_q, gray_q;
	logic [ITER_W-1:0]       res_gray_q;
	logic [COORD_W-1:0]      res_col_q, res_row_q;

	logic signed [OFF_W-1:0] re_off, im_off;
	logic signed [C_W-1:0]   cr_d, ci_d;
	logic [SQ_W:0]           mag_sum;
	logic                    esc;
	logic [ITER_W-1:0]       cnt_d;
	logic signed [T_W-1:0]   cr_ext, ci_ext, sr_ext, si_ext, x2_ext, tr_d, ti_d;
	logic [T_W-1:0]          ar, ai;
	logic [PROD_W-1:0]       p_rr, p_ii, p_ri;

	// c = origin + position * step, exact
	assign re_off = $signed({1'b0, col_q}) * $signed(cfg.re_step);
	assign im_off = $signed({1'b0, row_q}) * $signed(cfg.im_step);
	assign cr_d = $signed({{(C_W-ORIGIN_W){cfg.re_origin[ORIGIN_W-1]}}, cfg.re_origin})
		+ $signed({re_off[OFF_W-1], re_off});
	assign ci_d = $signed({{(C_W-ORIGIN_W){cfg.im_origin[ORIGIN_W-1]}}, cfg.im_origin})
		+ $signed({im_off[OFF_W-1], im_off});

	// escape test on the squares of the last new z
	assign mag_sum = {1'b0, sq_re_q} + {1'b0, sq_im_q};
	assign esc     = pend_q && (big_q || (mag_sum > {1'b0, cfg.escape_limit}));
	assign cnt_d   = cnt_q + {{(ITER_W-1){1'b0}}, pend_q};
	assign sts.done = esc || (cnt_d == cfg.max_iters);

	// next z from the squares of the current one
	assign cr_ext = $signed({{(T_W-C_W){cr_q[C_W-1]}}, cr_q});
	assign ci_ext = $signed({{(T_W-C_W){ci_q[C_W-1]}}, ci_q});
	assign sr_ext = $signed({{(T_W-SQ_W){1'b0}}, sq_re_q});
	assign si_ext = $signed({{(T_W-SQ_W){1'b0}}, sq_im_q});
	assign x2_ext = $signed({{(T_W-X2_W){1'b0}}, x2_q});
	assign tr_d   = sr_ext - si_ext + cr_ext;
	assign ti_d   = neg_q ? (ci_ext - x2_ext) : (ci_ext + x2_ext);

	// squares and cross product of the magnitudes; exact below 2^MAG_W
	assign ar   = tr_q[T_W-1] ? T_W'(-tr_q) : T_W'(tr_q);
	assign ai   = ti_q[T_W-1] ? T_W'(-ti_q) : T_W'(ti_q);
	assign p_rr = ar[MAG_W-1:0] * ar[MAG_W-1:0];
	assign p_ii = ai[MAG_W-1:0] * ai[MAG_W-1:0];
	assign p_ri = ar[MAG_W-1:0] * ai[MAG_W-1:0];

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			col_q <= pixel_col;
			row_q <= pixel_row;
		end
		if (cmd.load) begin
			cr_q    <= cr_d;
			ci_q    <= ci_d;
			sq_re_q <= '0;
			sq_im_q <= '0;
			x2_q    <= '0;
			big_q   <= 1'b0;
			neg_q   <= 1'b0;
			pend_q  <= 1'b0;
			cnt_q   <= '0;
		end
		if (cmd.step) begin
			if (sts.done) begin
				gray_q <= esc ? (cfg.max_iters - cnt_q) : '0;
			end else begin
				tr_q   <= tr_d;
				ti_q   <= ti_d;
				cnt_q  <= cnt_d;
				pend_q <= 1'b1;
			end
		end
		if (cmd.mul) begin
			sq_re_q <= p_rr[PROD_W-1:FRAC_BITS];
			sq_im_q <= p_ii[PROD_W-1:FRAC_BITS];
			x2_q    <= p_ri[PROD_W-1:FRAC_BITS-1];
			big_q   <= (|ar[T_W-1:MAG_W]) || (|ai[T_W-1:MAG_W]);
			neg_q   <= tr_q[T_W-1] ^ ti_q[T_W-1];
		end
		if (cmd.fin) begin
			res_gray_q <= gray_q;
			res_col_q  <= col_q;
			res_row_q  <= row_q;
		end
	end

	assign gray_value = res_gray_q;
	assign out_col    = res_col_q;
	assign out_row    = res_row_q;

endmodule

`default_nettype wire

[rtl/mandelbrot_escape_time_core.sv]
// Top level of the Mandelbrot escape-time core: configuration registers,
// controller and datapath. Depends on met_pkg, met_cfg, met_ctrl, met_dpath.
//
// Usage:
//  - Input channel (in_valid / in_stall) carries one word: pixel_col, pixel_row.
//    A word is taken when in_valid is high and in_stall low; in_stall is low
//    only while the core is idle, so one point is worked on at a time.
//  - Output channel (out_valid / out_stall) returns gray_value with the
//    position. The result sits in an output register, so the next word is
//    taken while a finished result still waits on a stalled receiver.
//  - Configuration channel (cfg_valid / cfg_ready, cfg_index, cfg_data)
//    writes register cfg_index: 0 re_origin, 1 im_origin, 2 re_step,
//    3 im_step, 4 escape_limit, 5 max_iters. Other indexes are dropped.
//    cfg_ready is always high; write only while the core is idle.
//  - Sequence: after a word is accepted, c is loaded, then each iteration is
//    one add step and one multiply step through the three multipliers, until
//    escape or max_iters iterations; a finish step then fills the output
//    register. The next word is taken only after the finish step of the last.
//  - Reset (arst_n low) loads the default view and max_iters = 255 and
//    drops any word in flight.
`timescale 1ns / 1ps
`default_nettype none

module mandelbrot_escape_time_core import met_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output logic                       in_stall,
	input  wire logic [COORD_W-1:0]    pixel_col,
	input  wire logic [COORD_W-1:0]    pixel_row,
	output logic                       out_valid,
	input  wire logic                  out_stall,
	output logic [ITER_W-1:0]          gray_value,
	output logic [COORD_W-1:0]         out_col,
	output logic [COORD_W-1:0]         out_row,
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);

	cfg_t cfg;
	cmd_t cmd;
	sts_t sts;

	// register file; the user is to keep values put while a point iterates; the block has no guard for it
	met_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// sequencer: idle, load c, then add / multiply until escape or budget
	met_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	// arithmetic, iteration counter and output payload register
	met_dpath u_dpath (
		.clk        (clk),
		.pixel_col  (pixel_col),
		.pixel_row  (pixel_row),
		.cfg        (cfg),
		.cmd        (cmd),
		.sts        (sts),
		.gray_value (gray_value),
		.out_col    (out_col),
		.out_row    (out_row)
	);

endmodule

`default_nettype wire
